// File: src/eii_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eii_pkg
// shared types, widths and codes of the energy interval integrator
// ----------------------------------------------------------------------------
package eii_pkg;

  localparam int TS_W            = 64;
  localparam int SUM_W           = 64;
  localparam int READING_FIELD_W = 32;
  localparam int TF_W            = 17;
  localparam int TF_MAG_W        = 16;
  localparam int MUL_B_W         = 32;
  localparam int CFG_INDEX_W     = 1;
  localparam int CFG_DATA_W      = 17;
  localparam int READING_WIDTH_DEF = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_MODE  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_FACTOR = 1'd1;

  localparam logic MODE_COUNTER = 1'b0;
  localparam logic MODE_POWER   = 1'b1;

  localparam logic signed [TF_W-1:0] TF_RESET = 17'sd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_COMMIT
  } eii_state_t;

endpackage

// File: src/eii_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eii_mul
// shift-add multiplier, one multiplier bit per cycle, product modulo 2^64
// ----------------------------------------------------------------------------
module eii_mul #(
  parameter int B_W = eii_pkg::MUL_B_W
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [eii_pkg::SUM_W-1:0] a,
  input  logic [B_W-1:0]           b,
  output logic                     busy,
  output logic [eii_pkg::SUM_W-1:0] product
);
  import eii_pkg::*;

  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] mcand;
  logic [B_W-1:0]   mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && (mplier == '0)) begin
      busy <= 1'b0;
    end
  end

  // stops as soon as no multiplier bits are left
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= a;
      mplier <= b;
    end else if (busy && (mplier != '0)) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[SUM_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[B_W-1:1]};
    end
  end

  assign product = acc;

  assert property (@(posedge clk) disable iff (rst)
    (busy && (mplier == '0) && !start) |=> !busy)
    else $error("multiplier did not finish after last bit");

  assert property (@(posedge clk) disable iff (rst)
    (busy && !start && (mplier != '0)) |=> ($countones(mplier) <= $countones($past(mplier))))
    else $error("multiplier bits grew while shifting");

  assert property (@(posedge clk) disable iff (rst)
    start |=> (busy && (acc == '0)))
    else $error("multiplier start did not clear accumulator");

endmodule

// File: src/eii_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eii_div
// restoring divider, one quotient bit per cycle, 64-bit by 17-bit unsigned
// ----------------------------------------------------------------------------
module eii_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [eii_pkg::SUM_W-1:0]   dividend,
  input  logic [eii_pkg::TF_W-1:0]    divisor,
  output logic                        busy,
  output logic [eii_pkg::SUM_W-1:0]   quotient
);
  import eii_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);

  logic [SUM_W-1:0] quo;
  logic [TF_W-1:0]  rem;
  logic [TF_W-1:0]  dsr;
  logic [CNT_W-1:0] cnt;
  logic [TF_W:0]    trial;
  logic [TF_W:0]    diff;
  logic             ge;

  assign trial = {rem, quo[SUM_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(SUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // remainder stays below the divisor, so it fits the divisor width
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[TF_W-1:0] : trial[TF_W-1:0];
      quo <= {quo[SUM_W-2:0], ge};
    end
  end

  assign quotient = quo;

  assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem < dsr))
    else $error("partial remainder not below divisor");

  assert property (@(posedge clk) disable iff (rst)
    start |=> (busy && (cnt == '0)))
    else $error("divider start did not reset step count");

  assert property (@(posedge clk) disable iff (rst)
    (busy && !start && (cnt == CNT_W'(SUM_W - 1))) |=> !busy)
    else $error("divider ran past its last step");

endmodule

// File: src/energy_interval_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// energy_interval_integrator
// integrates energy over framed sample intervals, rectangle rule
// ----------------------------------------------------------------------------
// Samples arrive on the s_ stream: tdata carries timestamp, energy and power
// readings, tuser marks the first sample of an interval, tlast the last one.
// Each last sample produces one beat on the m_ stream with the elapsed time
// and the energy consumed since the first sample, both modulo 2^64.
// The user sets source_mode and the scale factor on the cfg_ port while idle;
// the block itself does not enforce this. One sample is worked at a time.
// Counter mode and first samples pass from the sample register through
// DECIDE and COMMIT to the result register. Power mode runs a bit-serial
// shift-add multiplier (one power bit per cycle) and then either a second
// pass by the scale factor (one factor bit per cycle) or a restoring divider
// (one quotient bit per cycle) before COMMIT; after COMMIT the block returns
// to IDLE and takes the next sample.
// The result sits in an output register; the next sample is accepted while
// it waits. If a further last sample finishes while the receiver still
// stalls, the block holds that sample until the register frees up.
// Reset clears all interval state, sets source_mode 0 and the factor to 1.
// ----------------------------------------------------------------------------
module energy_interval_integrator #(
  parameter int READING_WIDTH = eii_pkg::READING_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // timestamp[63:0], energy_reading[95:64], power_reading[127:96]
  input  logic [127:0]                       s_tdata,
  // first_sample
  input  logic                               s_tuser,
  input  logic                               s_tlast,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // elapsed[63:0], energy_used[127:64]
  output logic [127:0]                       m_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic                               cfg_we,
  input  logic [eii_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [eii_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import eii_pkg::*;

  localparam int EFF_W = (READING_WIDTH < READING_FIELD_W) ? READING_WIDTH : READING_FIELD_W;

  eii_state_t state, state_next;

  logic                    source_mode;
  logic signed [TF_W-1:0]  scale_factor;

  logic [TS_W-1:0]  item_ts;
  logic [EFF_W-1:0] item_energy;
  logic [EFF_W-1:0] item_power;
  logic             item_first;
  logic             item_last;

  logic [TS_W-1:0]  start_time;
  logic [TS_W-1:0]  previous_time;
  logic [EFF_W-1:0] previous_power;
  logic [SUM_W-1:0] energy_sum;

  logic               mul_start;
  logic [SUM_W-1:0]   mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_busy;
  logic [SUM_W-1:0]   mul_product;

  logic               div_start;
  logic [TF_W-1:0]    tf_mag;
  logic               div_busy;
  logic [SUM_W-1:0]   div_quotient;

  logic               in_beat;
  logic               out_free;
  logic               out_load;

  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign tf_mag   = ~scale_factor + 1'b1;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      source_mode  <= MODE_COUNTER;
      scale_factor <= TF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOURCE_MODE:  source_mode  <= cfg_data[0];
        CFG_SCALE_FACTOR: scale_factor <= cfg_data[TF_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (item_first || (source_mode == MODE_COUNTER)) state_next = S_COMMIT;
        else state_next = S_MUL1;
      end
      S_MUL1: begin
        if (!mul_busy) state_next = scale_factor[TF_W-1] ? S_DIV : S_MUL2;
      end
      S_MUL2: begin
        if (!mul_busy) state_next = S_COMMIT;
      end
      S_DIV: begin
        if (!div_busy) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (!item_last || out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    mul_a     = item_ts - previous_time;
    mul_b     = MUL_B_W'(previous_power);
    case (state)
      S_IDLE: s_tready = 1'b1;
      S_DECIDE: begin
        mul_start = !item_first && (source_mode == MODE_POWER);
      end
      S_MUL1: begin
        mul_a     = mul_product;
        mul_b     = MUL_B_W'(scale_factor[TF_MAG_W-1:0]);
        mul_start = !mul_busy && !scale_factor[TF_W-1];
        div_start = !mul_busy && scale_factor[TF_W-1];
      end
      S_COMMIT: out_load = item_last && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sample holding register
  always_ff @(posedge clk) begin
    if (in_beat) begin
      item_ts     <= s_tdata[63:0];
      item_energy <= s_tdata[64 +: EFF_W];
      item_power  <= s_tdata[96 +: EFF_W];
      item_first  <= s_tuser;
      item_last   <= s_tlast;
    end
  end

  // interval state
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time     <= '0;
      previous_time  <= '0;
      previous_power <= '0;
      energy_sum     <= '0;
    end else begin
      case (state)
        S_DECIDE: begin
          if (item_first) begin
            start_time <= item_ts;
            energy_sum <= '0;
          end else if (source_mode == MODE_COUNTER) begin
            energy_sum <= energy_sum + SUM_W'(item_energy);
          end
        end
        S_MUL2: begin
          if (!mul_busy) energy_sum <= energy_sum + mul_product;
        end
        S_DIV: begin
          if (!div_busy) energy_sum <= energy_sum + div_quotient;
        end
        S_COMMIT: begin
          previous_time  <= item_ts;
          previous_power <= item_power;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {energy_sum, item_ts - start_time};
    end
  end

  eii_mul #(
    .B_W (MUL_B_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .busy    (mul_busy),
    .product (mul_product)
  );

  eii_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_product),
    .divisor  (tf_mag),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy)
    else $error("multiplier restarted while busy");

  assert property (@(posedge clk) disable iff (rst)
    div_start |-> (!div_busy && !mul_busy))
    else $error("divider started while an operation was running");

  assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!mul_busy && !div_busy))
    else $error("sample accepted while arithmetic still running");

  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_COMMIT))
    else $error("result raised outside of commit");

endmodule
